@@ hdl/ubjd_pkg.sv @@
// Package for the UBJSON value decoder: parse phases, markers, error codes
// and the marker size functions. No dependencies.
package ubjd_pkg;

   typedef enum logic [3:0] {
      PH_IDLE, PH_NUM, PH_LEN_MARK, PH_LEN_FIRST, PH_LEN_REST, PH_STR,
      PH_ARR_OPEN, PH_ARR_TYPE, PH_ARR_HASH, PH_CNT_MARK, PH_CNT_FIRST, PH_CNT_REST
   } phase_type;

   typedef enum logic [2:0] {
      KIND_INT, KIND_REAL, KIND_BOOL, KIND_KEY, KIND_STR,
      KIND_INTARR, KIND_REALARR, KIND_STRARR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE, ERR_MARKER, ERR_INT_TYPE, ERR_REAL_TYPE, ERR_BOOL,
      ERR_ARR_FORM, ERR_ARR_START, ERR_NEG_LEN
   } err_type;

   localparam logic [7:0] M_INT8 = 8'h69;
   localparam logic [7:0] M_UINT8 = 8'h55;
   localparam logic [7:0] M_INT16 = 8'h49;
   localparam logic [7:0] M_INT32 = 8'h6C;
   localparam logic [7:0] M_INT64 = 8'h4C;
   localparam logic [7:0] M_F32 = 8'h64;
   localparam logic [7:0] M_F64 = 8'h44;
   localparam logic [7:0] M_TRUE = 8'h54;
   localparam logic [7:0] M_FALSE = 8'h46;
   localparam logic [7:0] M_STR = 8'h53;
   localparam logic [7:0] M_DOLLAR = 8'h24;
   localparam logic [7:0] M_HASH = 8'h23;
   localparam logic [7:0] M_OPEN = 8'h5B;

   function automatic logic [3:0] int_size(input logic [7:0] m);
      case (m)
         M_INT8, M_UINT8: int_size = 4'd1;
         M_INT16: int_size = 4'd2;
         M_INT32: int_size = 4'd4;
         M_INT64: int_size = 4'd8;
         default: int_size = 4'd0;
      endcase
   endfunction

   function automatic logic [3:0] real_size(input logic [7:0] m);
      case (m)
         M_F32: real_size = 4'd4;
         M_F64: real_size = 4'd8;
         default: real_size = 4'd0;
      endcase
   endfunction

endpackage

@@ hdl/ubjd_number.sv @@
// Finishes an assembled big-endian number: sign/zero extension and exact
// float32 to binary64 widening. Uses ubjd_pkg.
module ubjd_number (
   input  logic [7:0]  marker,
   input  logic [63:0] raw,
   output logic [63:0] result
);
   import ubjd_pkg::*;

   logic [7:0]  exp8;
   logic [22:0] man;
   logic [4:0]  lz;
   logic [63:0] wide;
   logic [52:0] shifted;

   // leading-zero count over 23 bits (priority encoder, not a dependent chain)
   always_comb begin
      lz = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (man[i]) lz = 5'(22 - i);
      end
   end

   assign exp8 = raw[30:23];
   assign man = raw[22:0];
   assign shifted = {30'd0, man} << (6'd30 + 6'(lz));

   always_comb begin
      if (exp8 == 8'hFF) begin
         wide = {raw[31], 11'h7FF, man, 29'd0};
      end else if (exp8 == 8'd0) begin
         if (man == 23'd0) begin
            wide = {raw[31], 63'd0};
         end else begin
            wide = {raw[31], 11'(11'd896 - 11'(lz)), shifted[51:0]};
         end
      end else begin
         wide = {raw[31], 11'(11'(exp8) + 11'd896), man, 29'd0};
      end
   end

   always_comb begin
      case (marker)
         M_INT8: result = {{56{raw[7]}}, raw[7:0]};
         M_UINT8: result = {56'd0, raw[7:0]};
         M_INT16: result = {{48{raw[15]}}, raw[15:0]};
         M_INT32: result = {{32{raw[31]}}, raw[31:0]};
         M_F32: result = wide;
         default: result = raw;
      endcase
   end
endmodule

@@ hdl/ubjson_value_decoder_unit.sv @@
// UBJSON value decoder, top level. One encoded byte per input word.
// Uses ubjd_pkg and ubjd_number.
//
// Usage: req_ carries one stream byte per word plus mode, which is read only
// when a value starts. rsp_ carries zero or one result per input word:
// number, string byte, bool or an error, with element_end/last/empty_res.
// A result is registered and appears on rsp_ in the cycle after the byte
// that causes it is accepted. Throughput: one byte per cycle while not
// stalled; the parse state register is updated every accepted byte and
// the result register is the only stage. req_stall is raised only while
// a result is held and rsp_stall is high; the decode logic itself never waits.
// Reset (synchronous, active high) returns the parser to idle with all
// counters cleared and drops rsp_valid.
// While rsp_stall is high the held result stays unchanged; a new byte is
// accepted in the same cycle the held result is taken.
module ubjson_value_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [2:0]  req_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [63:0] rsp_value,
   output logic        rsp_element_end,
   output logic        rsp_last,
   output logic        rsp_empty_res,
   output logic [2:0]  rsp_error
);
   import ubjd_pkg::*;

   phase_type   phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  tm_ff, tm_in;
   logic [3:0]  pbl_ff, pbl_in;
   logic [63:0] asm_ff, asm_in;
   logic [62:0] el_ff, el_in;
   logic [62:0] sbl_ff, sbl_in;

   logic        rv_ff;
   logic [63:0] val_ff;
   logic        ee_ff, last_ff, emp_ff;
   logic [2:0]  err_ff;

   logic        emit;
   logic [63:0] e_val;
   logic        e_ee, e_last, e_emp;
   err_type     e_err;

   logic        acc;
   logic [7:0]  b;
   logic [63:0] asm_shift, num_val;
   logic [3:0]  pbl_dec;
   logic [62:0] el_dec, sbl_dec;
   logic [3:0]  bsz;

   assign req_stall = rv_ff & rsp_stall;
   assign acc = req_valid & ~req_stall;
   assign b = req_data_byte;
   assign asm_shift = {asm_ff[55:0], b};
   assign pbl_dec = pbl_ff - 4'd1;
   assign el_dec = el_ff - 63'd1;
   assign sbl_dec = sbl_ff - 63'd1;
   assign bsz = int_size(b);

   ubjd_number u_num (.marker(tm_ff), .raw(asm_shift), .result(num_val));

   always_comb begin
      phase_in = phase_ff; kind_in = kind_ff; tm_in = tm_ff; pbl_in = pbl_ff;
      asm_in = asm_ff; el_in = el_ff; sbl_in = sbl_ff;
      emit = 1'b0; e_val = 64'd0; e_ee = 1'b0; e_last = 1'b0; e_emp = 1'b0;
      e_err = ERR_NONE;
      case (phase_ff)
         PH_IDLE: begin
            kind_in = kind_type'(req_mode);
            case (kind_type'(req_mode))
               KIND_INT, KIND_REAL: begin
                  logic [3:0] s;
                  s = (req_mode == KIND_INT) ? bsz : real_size(b);
                  if (s == 4'd0) begin
                     emit = 1'b1; e_last = 1'b1;
                     e_err = (req_mode == KIND_INT) ? ERR_INT_TYPE : ERR_REAL_TYPE;
                  end else begin
                     el_in = 63'd1; tm_in = b; pbl_in = s; asm_in = 64'd0;
                     phase_in = PH_NUM;
                  end
               end
               KIND_BOOL: begin
                  emit = 1'b1; e_last = 1'b1;
                  if (b == M_TRUE) begin
                     e_val = 64'd1; e_ee = 1'b1;
                  end else if (b == M_FALSE) begin
                     e_ee = 1'b1;
                  end else begin
                     e_err = ERR_BOOL;
                  end
               end
               KIND_KEY: begin
                  if (bsz == 4'd0) begin
                     emit = 1'b1; e_last = 1'b1; e_err = ERR_INT_TYPE;
                  end else begin
                     pbl_in = bsz; asm_in = 64'd0;
                     phase_in = (b == M_UINT8) ? PH_LEN_REST : PH_LEN_FIRST;
                  end
               end
               KIND_STR: begin
                  if (b != M_STR) begin
                     emit = 1'b1; e_last = 1'b1; e_err = ERR_MARKER;
                  end else begin
                     phase_in = PH_LEN_MARK;
                  end
               end
               default: begin
                  if (b != M_OPEN) begin
                     emit = 1'b1; e_last = 1'b1; e_err = ERR_MARKER;
                  end else begin
                     phase_in = PH_ARR_OPEN;
                  end
               end
            endcase
         end
         PH_NUM: begin
            asm_in = asm_shift; pbl_in = pbl_dec;
            if (pbl_dec == 4'd0) begin
               el_in = el_dec;
               emit = 1'b1; e_val = num_val; e_ee = 1'b1; e_last = (el_dec == 63'd0);
               if (el_dec != 63'd0) begin
                  pbl_in = int_size(tm_ff) + real_size(tm_ff); asm_in = 64'd0;
               end
            end
         end
         PH_LEN_MARK, PH_CNT_MARK: begin
            if (bsz == 4'd0) begin
               emit = 1'b1; e_last = 1'b1; e_err = ERR_INT_TYPE;
            end else begin
               pbl_in = bsz; asm_in = 64'd0;
               if (phase_ff == PH_LEN_MARK) begin
                  phase_in = (b == M_UINT8) ? PH_LEN_REST : PH_LEN_FIRST;
               end else begin
                  phase_in = (b == M_UINT8) ? PH_CNT_REST : PH_CNT_FIRST;
               end
            end
         end
         PH_LEN_FIRST, PH_LEN_REST, PH_CNT_FIRST, PH_CNT_REST: begin
            logic [63:0] a;
            logic        is_cnt;
            a = (phase_ff == PH_LEN_FIRST || phase_ff == PH_CNT_FIRST) ?
                {{56{b[7]}}, b} : asm_shift;
            is_cnt = (phase_ff == PH_CNT_FIRST || phase_ff == PH_CNT_REST);
            asm_in = a; pbl_in = pbl_dec;
            phase_in = is_cnt ? PH_CNT_REST : PH_LEN_REST;
            if (pbl_dec == 4'd0) begin
               if (a[63]) begin
                  emit = 1'b1; e_last = 1'b1; e_err = ERR_NEG_LEN;
               end else if (is_cnt) begin
                  if (a == 64'd0) begin
                     emit = 1'b1; e_last = 1'b1; e_emp = 1'b1;
                  end else begin
                     el_in = a[62:0];
                     case (kind_ff)
                        KIND_INTARR: begin
                           if (int_size(tm_ff) == 4'd0) begin
                              emit = 1'b1; e_last = 1'b1; e_err = ERR_INT_TYPE;
                           end else begin
                              pbl_in = int_size(tm_ff); asm_in = 64'd0;
                              phase_in = PH_NUM;
                           end
                        end
                        KIND_REALARR: begin
                           tm_in = M_F64; pbl_in = 4'd8; asm_in = 64'd0;
                           phase_in = PH_NUM;
                        end
                        KIND_STRARR: phase_in = PH_LEN_MARK;
                        default: phase_in = PH_IDLE;
                     endcase
                  end
               end else begin
                  if (a == 64'd0) begin
                     emit = 1'b1; e_ee = 1'b1; e_emp = 1'b1; e_last = 1'b1;
                     if (kind_ff == KIND_STRARR) begin
                        el_in = el_dec; e_last = (el_dec == 63'd0);
                        phase_in = PH_LEN_MARK;
                     end
                  end else begin
                     sbl_in = a[62:0]; phase_in = PH_STR;
                  end
               end
            end
         end
         PH_STR: begin
            sbl_in = sbl_dec;
            emit = 1'b1; e_val = {56'd0, b};
            if (sbl_dec == 63'd0) begin
               e_ee = 1'b1; e_last = 1'b1;
               if (kind_ff == KIND_STRARR) begin
                  el_in = el_dec; e_last = (el_dec == 63'd0);
                  phase_in = PH_LEN_MARK;
               end
            end
         end
         PH_ARR_OPEN: begin
            if (b == M_DOLLAR) begin
               phase_in = PH_ARR_TYPE;
            end else begin
               emit = 1'b1; e_last = 1'b1;
               if (b == M_HASH || (kind_ff == KIND_INTARR && bsz != 4'd0) ||
                   (kind_ff == KIND_REALARR && real_size(b) != 4'd0) ||
                   (kind_ff == KIND_STRARR && b == M_STR)) begin
                  e_err = ERR_ARR_FORM;
               end else begin
                  e_err = ERR_ARR_START;
               end
            end
         end
         PH_ARR_TYPE: begin
            if ((kind_ff == KIND_REALARR && b != M_F64) ||
                (kind_ff == KIND_STRARR && b != M_STR)) begin
               emit = 1'b1; e_last = 1'b1; e_err = ERR_MARKER;
            end else begin
               tm_in = b; phase_in = PH_ARR_HASH;
            end
         end
         PH_ARR_HASH: begin
            if (b != M_HASH) begin
               emit = 1'b1; e_last = 1'b1; e_err = ERR_MARKER;
            end else begin
               phase_in = PH_CNT_MARK;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      if (emit && e_last) phase_in = PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; kind_ff <= KIND_INT; tm_ff <= 8'd0; pbl_ff <= 4'd0;
         asm_ff <= 64'd0; el_ff <= 63'd0; sbl_ff <= 63'd0; rv_ff <= 1'b0;
      end else begin
         if (acc) begin
            phase_ff <= phase_in; kind_ff <= kind_in; tm_ff <= tm_in;
            pbl_ff <= pbl_in; asm_ff <= asm_in; el_ff <= el_in; sbl_ff <= sbl_in;
         end
         if (acc) begin
            rv_ff <= emit;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc && emit) begin
         val_ff <= e_val; ee_ff <= e_ee; last_ff <= e_last; emp_ff <= e_emp;
         err_ff <= e_err;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_value = val_ff;
   assign rsp_element_end = ee_ff;
   assign rsp_last = last_ff;
   assign rsp_empty_res = emp_ff;
   assign rsp_error = err_ff;
endmodule

@@ hdl/ubjd_checker.sv @@
// Port-level checker for the UBJSON value decoder, bound to the top level.
// Depends only on the top-level ports.
module ubjd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_value,
   input logic        rsp_element_end,
   input logic        rsp_last,
   input logic        rsp_empty_res,
   input logic [2:0]  rsp_error
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_error))
      else $error("stalled result changed");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != 3'd0 |-> rsp_last && !rsp_element_end && rsp_value == 64'd0)
      else $error("error result malformed");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_value == 64'd0 && rsp_error == 3'd0)
      else $error("empty result malformed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without held result");
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind ubjson_value_decoder_unit ubjd_checker u_chk (.*);
